### src/pdr_pkg.sv
// Shared types, codes and constants of the PWM duty ramp/hold controller.
// No dependencies; the RTL files use it by scoped names, the bench imports it.
package pdr_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int OUT_CH           = 3;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [15:0] PERIOD_RESET  = 16'd1000;
    localparam logic [15:0] COMPARE_RESET = 16'd500;
    localparam logic [15:0] GOAL_RESET    = 16'd50;
    localparam logic [6:0]  PCT_MAX       = 7'd100;
    localparam logic [22:0] HOLD_SCALE    = 23'd100;

    // x / 100 == (x * GOAL_RECIP) >> 30 for x < 2^23
    localparam logic [46:0] GOAL_RECIP  = 47'd10737419;
    // x / 10 == (x * TENTH_RECIP) >> 35 for any 32-bit x
    localparam logic [63:0] TENTH_RECIP = 64'd3435973837;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DIR   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] DIR_BRAKE   = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;
    localparam logic [1:0] DIR_INVALID = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CH   = 2'd1;
    localparam logic [1:0] ST_BAD_DIR  = 2'd2;
    localparam logic [1:0] ST_HOLD_MIN = 2'd3;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_START,
        KIND_DIR,
        KIND_NOP,
        KIND_BAD_CH,
        KIND_BAD_DIR
    } t_kind;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  channel;
        logic [6:0]  duty_percent;
        logic [15:0] hold_seconds;
        logic [1:0]  direction;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] compare_first;
        logic [15:0] compare_second;
        logic [15:0] compare_third;
        logic [2:0]  active_mask;
        logic        bridge_forward;
        logic        bridge_reverse;
        logic        drive_on;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  lane;
        logic [1:0]  dir;
        logic [15:0] goal;
        logic [31:0] hold;
    } t_task;

endpackage

### src/pdr_front.sv
// Front end: accepts input items, classifies them and precomputes targets and holds.
// Two register stages; depends on pdr_pkg.
module pdr_front #(
    parameter int NUM_CHANNELS = pdr_pkg::NUM_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_period,
    input  logic              i_valid,
    output logic              o_ready,
    input  pdr_pkg::t_in_item i_data,
    output logic              o_valid,
    input  logic              i_q_ready,
    output pdr_pkg::t_task    o_task
);

    typedef struct packed {
        pdr_pkg::t_kind kind;
        logic [1:0]     lane;
        logic [1:0]     dir;
        logic           is_first;
        logic [22:0]    p_goal;
        logic [31:0]    p_hold;
        logic [22:0]    hold100;
    } t_s1;

    t_s1            r_s1, n_s1;
    logic           r_s1_valid;
    pdr_pkg::t_task r_s2, n_s2;
    logic           r_s2_valid;

    logic        w_s2_ready;
    logic        w_s1_ready;
    logic [6:0]  w_pct;
    logic [46:0] w_goal_prod;
    logic [63:0] w_hold_prod;

    assign w_s2_ready = !r_s2_valid || i_q_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_ready    = w_s1_ready;
    assign o_valid    = r_s2_valid;
    assign o_task     = r_s2;

    assign w_pct = (i_data.duty_percent > pdr_pkg::PCT_MAX) ? pdr_pkg::PCT_MAX
                                                            : i_data.duty_percent;

    always_comb begin
        n_s1          = '0;
        n_s1.lane     = i_data.channel - 2'd1;
        n_s1.dir      = i_data.direction;
        n_s1.is_first = (i_data.channel == 2'd1);
        n_s1.p_goal   = 23'(w_pct) * 23'(i_period);
        n_s1.p_hold   = 32'(i_data.hold_seconds) * 32'(i_period);
        n_s1.hold100  = 23'(i_data.hold_seconds) * pdr_pkg::HOLD_SCALE;
        case (i_data.opcode)
            pdr_pkg::OP_TICK: begin
                n_s1.kind = pdr_pkg::KIND_TICK;
            end
            pdr_pkg::OP_START: begin
                if (i_data.channel != 2'd0 && int'(i_data.channel) <= NUM_CHANNELS) begin
                    n_s1.kind = pdr_pkg::KIND_START;
                end else begin
                    n_s1.kind = pdr_pkg::KIND_BAD_CH;
                end
            end
            pdr_pkg::OP_DIR: begin
                if (i_data.direction == pdr_pkg::DIR_INVALID) begin
                    n_s1.kind = pdr_pkg::KIND_BAD_DIR;
                end else begin
                    n_s1.kind = pdr_pkg::KIND_DIR;
                end
            end
            default: begin
                n_s1.kind = pdr_pkg::KIND_NOP;
            end
        endcase
    end

    // constant-reciprocal division of the stage-one products
    assign w_goal_prod = 47'(r_s1.p_goal) * pdr_pkg::GOAL_RECIP;
    assign w_hold_prod = 64'(r_s1.p_hold) * pdr_pkg::TENTH_RECIP;

    always_comb begin
        n_s2      = '0;
        n_s2.kind = r_s1.kind;
        n_s2.lane = r_s1.lane;
        n_s2.dir  = r_s1.dir;
        n_s2.goal = w_goal_prod[45:30];
        if (r_s1.is_first) begin
            n_s2.hold = {3'b000, w_hold_prod[63:35]};
        end else begin
            n_s2.hold = {9'd0, r_s1.hold100};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_s1_ready) begin
            r_s1 <= n_s1;
        end
        if (r_s1_valid && w_s2_ready) begin
            r_s2 <= n_s2;
        end
    end

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !i_q_ready) |=> (r_s2_valid && $stable(r_s2)))
        else $error("front stage two lost or changed a stalled command");

endmodule

### src/pdr_queue.sv
// Short FIFO of classified commands between front and back.
// Depends on pdr_pkg.
module pdr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pdr_pkg::t_task i_data,
    output logic           o_ready,
    output logic           o_valid,
    output pdr_pkg::t_task o_data,
    input  logic           i_pop
);

    localparam int DEPTH = pdr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pdr_pkg::t_task   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push, w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

### src/pdr_back.sv
// Back end: channel ramp/hold lanes, direction latch and the result register.
// Depends on pdr_pkg.
module pdr_back #(
    parameter int NUM_CHANNELS = pdr_pkg::NUM_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_task_valid,
    input  pdr_pkg::t_task     i_task,
    output logic               o_task_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pdr_pkg::t_out_item o_out
);

    logic [15:0] r_duty [NUM_CHANNELS];
    logic [15:0] r_goal [NUM_CHANNELS];
    logic [31:0] r_hold [NUM_CHANNELS];
    logic [15:0] r_cmp  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_on;
    logic r_drive, r_fwd, r_rev;

    logic [15:0] n_duty [NUM_CHANNELS];
    logic [15:0] n_goal [NUM_CHANNELS];
    logic [31:0] n_hold [NUM_CHANNELS];
    logic [15:0] n_cmp  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] n_on;
    logic n_drive, n_fwd, n_rev;
    logic [1:0] n_status;

    pdr_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;

    logic        w_pop;
    logic [15:0] w_gap;
    logic [15:0] w_cmp3 [pdr_pkg::OUT_CH];
    logic [pdr_pkg::OUT_CH-1:0] w_mask3;

    assign w_pop       = i_task_valid && (!r_out_valid || i_out_ready);
    assign o_task_pop  = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // channel one: distance from last compare value to the new target
    assign w_gap = (i_task.goal > r_cmp[0]) ? (i_task.goal - r_cmp[0])
                                            : (r_cmp[0] - i_task.goal);

    always_comb begin
        logic [15:0] v_goal;
        v_goal   = '0;
        n_duty   = r_duty;
        n_goal   = r_goal;
        n_hold   = r_hold;
        n_cmp    = r_cmp;
        n_on     = r_on;
        n_drive  = r_drive;
        n_fwd    = r_fwd;
        n_rev    = r_rev;
        n_status = pdr_pkg::ST_OK;
        case (i_task.kind)
            pdr_pkg::KIND_TICK: begin
                if (r_drive) begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (r_on[c]) begin
                            v_goal = (r_hold[c] == '0) ? 16'd0 : r_goal[c];
                            n_goal[c] = v_goal;
                            n_cmp[c]  = r_duty[c];
                            if (r_duty[c] < v_goal) begin
                                n_duty[c] = r_duty[c] + 16'd1;
                            end else if (r_duty[c] > v_goal) begin
                                n_duty[c] = r_duty[c] - 16'd1;
                            end else begin
                                n_hold[c] = r_hold[c] - 32'd1;
                            end
                            if (n_duty[c] == '0) begin
                                n_on[c] = 1'b0;
                            end
                        end
                    end
                end
            end
            pdr_pkg::KIND_START: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (int'(i_task.lane) == c) begin
                        n_on[c]   = 1'b1;
                        n_goal[c] = i_task.goal;
                        n_duty[c] = r_cmp[c];
                        n_hold[c] = i_task.hold;
                        if (c == 0 && i_task.hold < {16'd0, w_gap}) begin
                            n_hold[c] = 32'd1;
                            n_status  = pdr_pkg::ST_HOLD_MIN;
                        end
                    end
                end
            end
            pdr_pkg::KIND_DIR: begin
                case (i_task.dir)
                    pdr_pkg::DIR_FORWARD: begin
                        n_drive = 1'b1;
                        n_fwd   = 1'b1;
                        n_rev   = 1'b0;
                    end
                    pdr_pkg::DIR_REVERSE: begin
                        n_drive = 1'b1;
                        n_fwd   = 1'b0;
                        n_rev   = 1'b1;
                    end
                    default: begin
                        n_drive = 1'b0;
                        n_fwd   = 1'b0;
                        n_rev   = 1'b0;
                    end
                endcase
            end
            pdr_pkg::KIND_BAD_CH: begin
                n_status = pdr_pkg::ST_BAD_CH;
            end
            pdr_pkg::KIND_BAD_DIR: begin
                n_status = pdr_pkg::ST_BAD_DIR;
            end
            default: begin
            end
        endcase
    end

    // channels past the configured count read as zero
    for (genvar c = 0; c < pdr_pkg::OUT_CH; c++) begin : g_out
        if (c < NUM_CHANNELS) begin : g_live
            assign w_cmp3[c]  = n_cmp[c];
            assign w_mask3[c] = n_on[c];
        end else begin : g_none
            assign w_cmp3[c]  = '0;
            assign w_mask3[c] = 1'b0;
        end
    end

    always_comb begin
        n_out                = '0;
        n_out.status         = n_status;
        n_out.compare_first  = w_cmp3[0];
        n_out.compare_second = w_cmp3[1];
        n_out.compare_third  = w_cmp3[2];
        n_out.active_mask    = w_mask3;
        n_out.bridge_forward = n_fwd;
        n_out.bridge_reverse = n_rev;
        n_out.drive_on       = n_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_duty[c] <= '0;
                r_goal[c] <= pdr_pkg::GOAL_RESET;
                r_hold[c] <= '0;
                r_cmp[c]  <= pdr_pkg::COMPARE_RESET;
            end
            r_on        <= '0;
            r_drive     <= 1'b0;
            r_fwd       <= 1'b0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_duty      <= n_duty;
                r_goal      <= n_goal;
                r_hold      <= n_hold;
                r_cmp       <= n_cmp;
                r_on        <= n_on;
                r_drive     <= n_drive;
                r_fwd       <= n_fwd;
                r_rev       <= n_rev;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= n_out;
        end
    end

    a_hold_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && n_status == pdr_pkg::ST_HOLD_MIN) |=> (r_hold[0] == 32'd1 && r_on[0]))
        else $error("raised hold not latched on channel one");

    a_bridge_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive == (r_fwd || r_rev) && !(r_fwd && r_rev))
        else $error("bridge pins disagree with drive enable");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (!o_task_pop || !$past(w_pop) || r_out_valid))
        else $error("result register overwritten while stalled");

endmodule

### src/pwm_duty_ramp_hold_controller.sv
// Top level of the three-channel PWM duty ramp/hold controller.
// Depends on pdr_pkg, pdr_front, pdr_queue and pdr_back.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  config   | in        | i_cfg_we               | i_cfg_data (pwm_period)
//  command  | in        | i_in_valid / o_in_ready| i_in_data  (t_in_item)
//  result   | out       | o_out_valid/i_out_ready| o_out_data (t_out_item)
//
// One item per cycle sustained while results are taken; each item gives one result after it
// passes the two front stages (target/hold reciprocal multipliers), the queue and result reg.
// Synchronous active-low reset; pwm_period resets to 1000, no clearing pass.
// A stalled result leaves the back end waiting; the two-entry queue and front stages keep
// taking commands until they fill.
module pwm_duty_ramp_hold_controller #(
    parameter int NUM_CHANNELS = pdr_pkg::NUM_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pdr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pdr_pkg::t_out_item o_out_data
);

    logic [15:0]    r_pwm_period;
    logic           w_f_valid, w_q_ready, w_q_valid, w_pop;
    pdr_pkg::t_task w_f_task, w_q_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= pdr_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_pwm_period <= i_cfg_data;
        end
    end

    pdr_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_period  (r_pwm_period),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_data    (i_in_data),
        .o_valid   (w_f_valid),
        .i_q_ready (w_q_ready),
        .o_task    (w_f_task)
    );

    pdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_task),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_task),
        .i_pop   (w_pop)
    );

    pdr_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (w_q_valid),
        .i_task       (w_q_task),
        .o_task_pop   (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out_data)
    );

endmodule

### verif/pwm_duty_ramp_hold_controller_test.sv
`timescale 1ns / 1ps
// Self-checking bench for pwm_duty_ramp_hold_controller: random command traffic,
// period changes between phases, a scoreboard class that predicts every result.
// Depends on pdr_pkg and the controller RTL.
module pwm_duty_ramp_hold_controller_test;
    import pdr_pkg::*;

    localparam int NCH            = NUM_CHANNELS_DEF;
    localparam int SENDER         = 0;
    localparam int RECEIVER       = 1;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    class duty_ramp_scoreboard;
        logic [15:0] period;
        logic [15:0] duty_now [NCH];
        logic [15:0] duty_goal [NCH];
        logic [31:0] hold_left [NCH];
        bit          chan_on [NCH];
        logic [15:0] compare [NCH];
        bit          drive_en;
        bit          pin_fwd;
        bit          pin_rev;
        t_out_item   expected_results[$];
        int          mismatches;

        function new();
            int c;
            period = PERIOD_RESET;
            for (c = 0; c < NCH; c++) begin
                duty_now[c]  = '0;
                duty_goal[c] = GOAL_RESET;
                hold_left[c] = '0;
                chan_on[c]   = 1'b0;
                compare[c]   = COMPARE_RESET;
            end
            drive_en   = 1'b0;
            pin_fwd    = 1'b0;
            pin_rev    = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted command to the model state and queue its result.
        function void note_command(t_in_item cmd);
            t_out_item   res;
            int unsigned pct;
            int unsigned goal;
            int unsigned gap;
            int unsigned hold_t;
            int          c;
            res = '0;
            res.status = ST_OK;
            case (cmd.opcode)
                OP_TICK: begin
                    if (drive_en) begin
                        for (c = 0; c < NCH; c++) begin
                            if (chan_on[c]) begin
                                if (hold_left[c] == 0) duty_goal[c] = '0;
                                compare[c] = duty_now[c];
                                if (duty_now[c] < duty_goal[c]) duty_now[c] = duty_now[c] + 1;
                                else if (duty_now[c] > duty_goal[c]) duty_now[c] = duty_now[c] - 1;
                                else hold_left[c] = hold_left[c] - 1;
                                if (duty_now[c] == 0) chan_on[c] = 1'b0;
                            end
                        end
                    end
                end
                OP_START: begin
                    if (cmd.channel == 0 || cmd.channel > NCH) begin
                        res.status = ST_BAD_CH;
                    end else begin
                        c = cmd.channel - 1;
                        pct = (cmd.duty_percent > PCT_MAX) ? 32'(PCT_MAX) : 32'(cmd.duty_percent);
                        goal = pct * 32'(period) / 100;
                        chan_on[c]   = 1'b1;
                        duty_goal[c] = goal[15:0];
                        duty_now[c]  = compare[c];
                        if (c == 0) begin
                            gap = (goal > compare[0]) ? goal - compare[0] : compare[0] - goal;
                            hold_t = 32'(cmd.hold_seconds) * 32'(period) / 10;
                            if (hold_t < gap) begin
                                hold_left[0] = 1;
                                res.status = ST_HOLD_MIN;
                            end else begin
                                hold_left[0] = hold_t;
                            end
                        end else begin
                            hold_left[c] = 32'(cmd.hold_seconds) * 100;
                        end
                    end
                end
                OP_DIR: begin
                    case (cmd.direction)
                        DIR_BRAKE: begin
                            drive_en = 1'b0; pin_fwd = 1'b0; pin_rev = 1'b0;
                        end
                        DIR_FORWARD: begin
                            drive_en = 1'b1; pin_fwd = 1'b1; pin_rev = 1'b0;
                        end
                        DIR_REVERSE: begin
                            drive_en = 1'b1; pin_fwd = 1'b0; pin_rev = 1'b1;
                        end
                        default: res.status = ST_BAD_DIR;
                    endcase
                end
                default: ;
            endcase
            res.compare_first  = compare[0];
            res.compare_second = compare[1];
            res.compare_third  = compare[2];
            for (c = 0; c < NCH; c++) res.active_mask[c] = chan_on[c];
            res.bridge_forward = pin_fwd;
            res.bridge_reverse = pin_rev;
            res.drive_on       = drive_en;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $error("result with no command pending: %h", got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("compare_first", want.compare_first, got.compare_first);
            compare_field("compare_second", want.compare_second, got.compare_second);
            compare_field("compare_third", want.compare_third, got.compare_third);
            compare_field("active_mask", want.active_mask, got.active_mask);
            compare_field("bridge_forward", want.bridge_forward, got.bridge_forward);
            compare_field("bridge_reverse", want.bridge_reverse, got.bridge_reverse);
            compare_field("drive_on", want.drive_on, got.drive_on);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    t_in_item    cmd_data  = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    t_out_item   res_data;

    duty_ramp_scoreboard sb;
    int calm_left [2];
    int idle_cycles = 0;

    pwm_duty_ramp_hold_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_in_data   (cmd_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Per-item wait, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(8, 40);
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] op, logic [1:0] ch, logic [6:0] pct,
                                          logic [15:0] secs, logic [1:0] dir);
        t_in_item cmd;
        cmd.opcode       = op;
        cmd.channel      = ch;
        cmd.duty_percent = pct;
        cmd.hold_seconds = secs;
        cmd.direction    = dir;
        return cmd;
    endfunction

    function automatic t_in_item random_command();
        t_in_item    cmd;
        int unsigned roll;
        int unsigned near;
        // unused fields carry random noise
        cmd.channel      = 2'($urandom_range(0, 3));
        cmd.duty_percent = 7'($urandom_range(0, 127));
        cmd.hold_seconds = 16'($urandom_range(0, 65535));
        cmd.direction    = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
            cmd.opcode = OP_TICK;
        end else if (roll < 86) begin
            cmd.opcode  = OP_START;
            cmd.channel = ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            roll = $urandom_range(0, 99);
            // aim near the current compare so ramps finish and holds expire
            if (roll < 60 && cmd.channel != 0 && sb.period != 0) begin
                near = 32'(sb.compare[cmd.channel - 1]) * 100 / 32'(sb.period);
                if (sb.period <= 1000) near += $urandom_range(0, 2);
                cmd.duty_percent = (near > 100) ? PCT_MAX : 7'(near);
            end else if (roll < 85) begin
                cmd.duty_percent = 7'($urandom_range(0, 10));
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) cmd.hold_seconds = 16'($urandom_range(0, 3));
            else if (roll < 90) cmd.hold_seconds = 16'($urandom_range(0, 50));
        end else if (roll < 94) begin
            cmd.opcode = OP_DIR;
            roll = $urandom_range(0, 19);
            if (roll < 14) cmd.direction = roll[0] ? DIR_FORWARD : DIR_REVERSE;
            else if (roll < 17) cmd.direction = DIR_BRAKE;
            else cmd.direction = DIR_INVALID;
        end else begin
            cmd.opcode = OP_NOP;
        end
        return cmd;
    endfunction

    task automatic send_command(t_in_item cmd);
        int n;
        n = draw_wait(SENDER);
        if (n > 0) begin
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= cmd;
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
        sb.note_command(cmd);
    endtask

    // Stop sending and wait until every queued result is back.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(logic [15:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.period = value;
    endtask

    initial begin : result_sink
        int n;
        wait (rst_n === 1'b1);
        forever begin
            n = draw_wait(RECEIVER);
            if (n > 0) begin
                res_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && res_ready));
            sb.check_result(res_data);
        end
    end

    always @(posedge clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item    directed[$];
        logic [15:0] phase_period [PHASES];
        int          p;
        int          i;
        int          drain_at;
        sb = new();
        phase_period = '{16'd100, 16'd100, 16'd100, 16'd65535, 16'd0, 16'd1000, 16'd0, 16'd100};
        phase_period[6] = 16'($urandom_range(100, 65535));

        // ticks with drive off, bad codes, saturation, minimum hold, both bridge sides
        directed.push_back(make_cmd(OP_TICK, 2'd1, 7'd0, 16'd0, DIR_BRAKE));
        directed.push_back(make_cmd(OP_NOP, 2'd3, 7'd127, 16'hFFFF, DIR_INVALID));
        directed.push_back(make_cmd(OP_START, 2'd0, 7'd50, 16'd5, DIR_BRAKE));
        directed.push_back(make_cmd(OP_DIR, 2'd0, 7'd0, 16'd0, DIR_INVALID));
        directed.push_back(make_cmd(OP_START, 2'd1, 7'd127, 16'd0, DIR_BRAKE));
        directed.push_back(make_cmd(OP_START, 2'd2, 7'd0, 16'hFFFF, DIR_BRAKE));
        directed.push_back(make_cmd(OP_START, 2'd3, 7'd100, 16'd1, DIR_BRAKE));
        directed.push_back(make_cmd(OP_DIR, 2'd0, 7'd0, 16'd0, DIR_FORWARD));
        repeat (6) directed.push_back(make_cmd(OP_TICK, 2'd0, 7'd0, 16'd0, DIR_BRAKE));
        directed.push_back(make_cmd(OP_START, 2'd1, 7'd50, 16'hFFFF, DIR_BRAKE));
        directed.push_back(make_cmd(OP_DIR, 2'd0, 7'd0, 16'd0, DIR_REVERSE));
        repeat (3) directed.push_back(make_cmd(OP_TICK, 2'd0, 7'd0, 16'd0, DIR_BRAKE));
        directed.push_back(make_cmd(OP_DIR, 2'd0, 7'd0, 16'd0, DIR_BRAKE));
        directed.push_back(make_cmd(OP_TICK, 2'd0, 7'd0, 16'd0, DIR_BRAKE));
        directed.push_back(make_cmd(OP_DIR, 2'd0, 7'd0, 16'd0, DIR_FORWARD));
        directed.push_back(make_cmd(OP_START, 2'd2, 7'd1, 16'd0, DIR_BRAKE));
        repeat (2) directed.push_back(make_cmd(OP_TICK, 2'd0, 7'd0, 16'd0, DIR_BRAKE));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < PHASES; p++) begin
            write_period(phase_period[p]);
            if (p == 0) begin
                foreach (directed[k]) send_command(directed[k]);
            end
            drain_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == drain_at) drain_results();
                send_command(random_command());
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
